/* hw/rtl/aplm_pkg.sv */
`default_nettype none
package aplm_pkg;

  localparam int SampleW  = 16;
  localparam int LevelW   = 7;
  localparam int PeakW    = 16;
  localparam int LogOffset = 6;
  localparam int LogSteps  = PeakW - LogOffset;
  localparam int SumW      = LevelW + 2;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      block_end;
  } in_t;

  typedef struct packed {
    logic [LevelW-1:0] smoothed_level;
    logic [LevelW-1:0] block_raw_level;
  } out_t;

  // (bits-6)*100/9 clamped to 100, indexed by floor(log2(peak)) - 6
  localparam logic [LevelW-1:0] LEVEL_TBL [LogSteps] = '{
    7'd0, 7'd11, 7'd22, 7'd33, 7'd44, 7'd55, 7'd66, 7'd77, 7'd88, 7'd100
  };

  function automatic logic [LevelW-1:0] peak_level(input logic [PeakW-1:0] peak);
    logic [LevelW-1:0] lvl;
    lvl = '0;
    for (int i = 0; i < LogSteps; i++) begin
      if (peak[LogOffset+i]) begin
        lvl = LEVEL_TBL[i];
      end
    end
    return lvl;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/aplm_level.sv */
`default_nettype none
module aplm_level (
  input  wire logic [aplm_pkg::PeakW-1:0]  peak,
  input  wire logic [aplm_pkg::LevelW-1:0] meter,
  output logic      [aplm_pkg::LevelW-1:0] raw_level,
  output logic      [aplm_pkg::LevelW-1:0] meter_nxt
);

  logic [aplm_pkg::SumW-1:0] sum;

  always_comb begin
    raw_level = aplm_pkg::peak_level(peak);
    sum = {1'b0, meter, 1'b0} + {2'b00, meter} + {2'b00, raw_level};
    meter_nxt = sum[aplm_pkg::SumW-1:2];
  end

endmodule
`default_nettype wire

/* hw/rtl/audio_peak_level_meter_top.sv */
`default_nettype none
// Channel | Ports                         | Beat
// in      | in_valid, in_stall, in_data   | one sample, block_end flag
// out     | out_valid, out_stall, out_data| smoothed and raw level, one per block
//
// One sample per cycle sustained while the input is not stalled. A sample
// sits in the input register, where it updates the running peak; a block-end
// sample then moves through the level stage (log table and smoothing add) to
// the output register. Reset clears peak, meter and all valid flags. A stalled
// output holds the level stage; the input stalls only when a block-end sample
// cannot move into it.
module audio_peak_level_meter_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire aplm_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output aplm_pkg::out_t     out_data
);

  aplm_pkg::in_t                    s1_r;
  logic                             s1_v_r, s1_v_nxt;
  logic [aplm_pkg::PeakW-1:0]       peak_r, peak_nxt;
  logic [aplm_pkg::PeakW-1:0]       s2_peak_r;
  logic                             s2_v_r, s2_v_nxt;
  logic [aplm_pkg::LevelW-1:0]      meter_r;
  logic [aplm_pkg::LevelW-1:0]      meter_nxt, raw_level;
  aplm_pkg::out_t                   out_r;
  logic                             out_v_r, out_v_nxt;
  logic [aplm_pkg::PeakW-1:0]       mag, peak_max;
  logic                             in_fire, s1_fire, s2_fire, out_adv, s2_adv;

  assign out_adv  = !out_v_r || !out_stall;
  assign s2_adv   = !s2_v_r || out_adv;
  assign s1_fire  = s1_v_r && (!s1_r.block_end || s2_adv);
  assign s2_fire  = s2_v_r && out_adv;
  assign in_stall = s1_v_r && !s1_fire;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    mag = s1_r.sample[aplm_pkg::SampleW-1] ? (~s1_r.sample + 16'd1) : s1_r.sample;
    peak_max = (mag > peak_r) ? mag : peak_r;
    peak_nxt = peak_r;
    if (s1_fire) begin
      peak_nxt = s1_r.block_end ? '0 : peak_max;
    end
    s1_v_nxt  = in_fire || (s1_v_r && !s1_fire);
    s2_v_nxt  = (s1_fire && s1_r.block_end) || (s2_v_r && !out_adv);
    out_v_nxt = s2_fire || (out_v_r && out_stall);
  end

  aplm_level u_level (
    .peak      (s2_peak_r),
    .meter     (meter_r),
    .raw_level (raw_level),
    .meter_nxt (meter_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      peak_r  <= '0;
      meter_r <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
      peak_r  <= peak_nxt;
      if (s2_fire) begin
        meter_r <= meter_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= in_data;
    end
    if (s1_fire && s1_r.block_end) begin
      s2_peak_r <= peak_max;
    end
    if (s2_fire) begin
      out_r.smoothed_level  <= meter_nxt;
      out_r.block_raw_level <= raw_level;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r <= 16'd32768)
    else $error("running peak out of range");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.smoothed_level <= 7'd100 && out_r.block_raw_level <= 7'd100))
    else $error("level out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s1_r.block_end && s2_v_r && out_v_r))
    else $error("input stalled without a full level path");

  a_meter_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(s2_fire) && $past(rst_n) |-> $stable(meter_r))
    else $error("meter changed without a block result");

endmodule
`default_nettype wire

/* verif/testbench.sv */
`default_nettype none
module testbench;

  class level_scoreboard;
    aplm_pkg::out_t              pending_levels[$];
    logic [aplm_pkg::PeakW-1:0]  peak;
    logic [aplm_pkg::LevelW-1:0] meter;
    int                          errors;

    function new();
      peak   = '0;
      meter  = '0;
      errors = 0;
    endfunction

    function int log_level(logic [aplm_pkg::PeakW-1:0] p);
      int msb;
      int lvl;
      msb = -1;
      for (int i = 0; i < aplm_pkg::PeakW; i++) begin
        if (p[i]) begin
          msb = i;
        end
      end
      if (msb < 6) begin
        return 0;
      end
      lvl = (msb - 6) * 100 / 9;
      if (lvl > 100) begin
        lvl = 100;
      end
      return lvl;
    endfunction

    function void note_sample(aplm_pkg::in_t d);
      logic [16:0]    mag;
      int             raw;
      aplm_pkg::out_t lv;
      if (d.sample[aplm_pkg::SampleW-1]) begin
        mag = 17'h10000 - {1'b0, d.sample};
      end else begin
        mag = {1'b0, d.sample};
      end
      if (mag > {1'b0, peak}) begin
        peak = mag[aplm_pkg::PeakW-1:0];
      end
      if (d.block_end) begin
        raw   = log_level(peak);
        meter = aplm_pkg::LevelW'((int'(meter) * 3 + raw) / 4);
        peak  = '0;
        lv.smoothed_level  = meter;
        lv.block_raw_level = aplm_pkg::LevelW'(raw);
        pending_levels.push_back(lv);
      end
    endfunction

    function void check_levels(aplm_pkg::out_t got);
      aplm_pkg::out_t want;
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected beat, smoothed %0d raw %0d", $time,
                 got.smoothed_level, got.block_raw_level);
        errors++;
        return;
      end
      want = pending_levels.pop_front();
      if (got.smoothed_level !== want.smoothed_level) begin
        $display("%0t: smoothed_level expected %0d actual %0d", $time,
                 want.smoothed_level, got.smoothed_level);
        errors++;
      end
      if (got.block_raw_level !== want.block_raw_level) begin
        $display("%0t: block_raw_level expected %0d actual %0d", $time,
                 want.block_raw_level, got.block_raw_level);
        errors++;
      end
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  aplm_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  aplm_pkg::out_t out_data;

  level_scoreboard sb = new();
  bit calm = 1'b0;
  int gap_rate = 0;
  int stall_rate = 0;

  audio_peak_level_meter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_levels(out_data);
    end
  end

  task automatic send_sample(input logic signed [aplm_pkg::SampleW-1:0] s,
                             input logic last);
    aplm_pkg::in_t d;
    d.sample    = s;
    d.block_end = last;
    if (!calm && gap_rate != 0 && $urandom_range(0, 7) < gap_rate) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
    sb.note_sample(d);
  endtask

  task automatic drain_levels();
    in_valid <= 1'b0;
    while (sb.pending_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [aplm_pkg::SampleW-1:0] pick_sample(bit hush);
    int          kind;
    int          sh;
    logic [15:0] mag;
    kind = $urandom_range(0, 19);
    if (hush) begin
      mag = 16'($urandom_range(0, 63));
    end else if (kind == 0) begin
      return 16'sh8000;
    end else if (kind < 4) begin
      return 16'($urandom);
    end else if (kind == 4) begin
      mag = '0;
    end else begin
      sh  = $urandom_range(0, 14);
      mag = 16'((1 << sh) | ($urandom & ((1 << sh) - 1)));
    end
    return $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
  endfunction

  initial begin
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) begin
        stall_rate = $urandom_range(0, 3);
      end
      if (!calm && stall_rate != 0 && $urandom_range(0, 7) < stall_rate) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  initial begin
    int  sent;
    int  blen;
    bit  hush;
    bit  paused;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sample(16'sd0, 1'b1);
    send_sample(16'sd32767, 1'b1);
    send_sample(-16'sd32768, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd63, 1'b1);
    send_sample(16'sd64, 1'b1);
    send_sample(-16'sd64, 1'b1);
    send_sample(-16'sd63, 1'b1);
    send_sample(16'sd127, 1'b0);
    send_sample(16'sd128, 1'b0);
    send_sample(-16'sd4096, 1'b0);
    send_sample(16'sd1000, 1'b1);
    send_sample(16'sd16384, 1'b1);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shAAAA, 1'b1);
    send_sample(16'sd3, 1'b1);
    send_sample(-16'sd2, 1'b1);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd1, 1'b1);
    send_sample(-16'sd32767, 1'b0);
    send_sample(16'sd256, 1'b0);
    send_sample(16'sd512, 1'b1);
    drain_levels();

    sent   = 0;
    paused = 1'b0;
    while (sent < 1250) begin
      blen     = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                             : $urandom_range(1, 12);
      hush     = ($urandom_range(0, 7) == 0);
      gap_rate = $urandom_range(0, 4);
      calm     = (sent >= 1100);
      for (int i = 0; i < blen; i++) begin
        send_sample(pick_sample(hush), i == blen - 1);
        sent++;
      end
      if (!paused && sent >= 600) begin
        paused = 1'b1;
        drain_levels();
      end
    end

    in_valid <= 1'b0;
    while (sb.pending_levels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
hw/rtl/aplm_pkg.sv
hw/rtl/aplm_level.sv
hw/rtl/audio_peak_level_meter_top.sv
verif/testbench.sv
